// ===== hdl/bhmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button hold mode controller package
// Mode encodings, button bit positions, command codes and register indexes.
// ----------------------------------------------------------------------------
package bhmc_pkg;

  // Internal mode state, one-hot.
  typedef enum logic [2:0] {
    MODE_ST_STATUS   = 3'b001,
    MODE_ST_THRUSTER = 3'b010,
    MODE_ST_WINDLASS = 3'b100
  } mode_state_t;

  // Mode as reported on the result channel.
  typedef logic [1:0] mode_code_t;
  localparam mode_code_t MODE_CODE_STATUS   = 2'd0;
  localparam mode_code_t MODE_CODE_THRUSTER = 2'd1;
  localparam mode_code_t MODE_CODE_WINDLASS = 2'd2;
  localparam mode_code_t MODE_CODE_UNUSED   = 2'd3;

  // Pressed set, one bit per button.
  typedef logic [4:0] button_set_t;
  localparam button_set_t KEY_NONE  = 5'b00000;
  localparam button_set_t KEY_LEFT  = 5'b00001;
  localparam button_set_t KEY_RIGHT = 5'b00010;
  localparam button_set_t KEY_UP    = 5'b00100;
  localparam button_set_t KEY_DOWN  = 5'b01000;
  localparam button_set_t KEY_OK    = 5'b10000;

  // Thruster commands.
  typedef logic [1:0] thruster_cmd_t;
  localparam thruster_cmd_t TCMD_STOP      = 2'd0;
  localparam thruster_cmd_t TCMD_RUN_PLUS  = 2'd1;
  localparam thruster_cmd_t TCMD_RUN_MINUS = 2'd2;

  // Windlass commands.
  typedef logic [2:0] windlass_cmd_t;
  localparam windlass_cmd_t WCMD_STOP        = 3'd0;
  localparam windlass_cmd_t WCMD_RUN_PLUS    = 3'd1;
  localparam windlass_cmd_t WCMD_RUN_MINUS   = 3'd2;
  localparam windlass_cmd_t WCMD_FORCE_PLUS  = 3'd3;
  localparam windlass_cmd_t WCMD_FORCE_MINUS = 3'd4;

  // Configuration registers.
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_LONG_PRESS  = 1'b0;
  localparam cfg_index_t CFG_SHORT_PRESS = 1'b1;

  localparam logic [15:0] LONG_PRESS_RESET  = 16'd3000;
  localparam logic [15:0] SHORT_PRESS_RESET = 16'd100;

  function automatic mode_code_t mode_code(input mode_state_t st);
    mode_code_t code;
    case (st)
      MODE_ST_THRUSTER: code = MODE_CODE_THRUSTER;
      MODE_ST_WINDLASS: code = MODE_CODE_WINDLASS;
      default:          code = MODE_CODE_STATUS;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/button_hold_mode_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Button hold mode controller
// Tracks the pressed button set and its hold time, switches between status,
// thruster and windlass modes on a long OK press, and issues motor commands.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+------------------------------
//  in      | sink      | in_valid / in_stall   | five pin levels, now_ms
//  out     | source    | out_valid / out_stall | mode, commands, pressed set
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One sample is accepted per cycle while in_stall is low. A sample is
//  captured in the input register, evaluated there and lands in the result
//  register when the result register can take a value. The hold state is
//  updated in the cycle the sample moves into the result register, so
//  back-to-back samples see each other's updates. A stall on the result
//  side holds the result register and then the input register; in_stall
//  rises only when both are full. Reset puts the block in thruster mode
//  with nothing pressed, a zero change time and default thresholds.
//  Configuration writes are always ready and take effect at once.
//
module button_hold_mode_controller_unit import bhmc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // Sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 left_level,
  input  logic                 right_level,
  input  logic                 up_level,
  input  logic                 down_level,
  input  logic                 ok_level,
  input  logic [TIME_BITS-1:0] now_ms,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           mode,
  output logic                 thruster_valid,
  output logic [1:0]           thruster_cmd,
  output logic                 windlass_valid,
  output logic [2:0]           windlass_cmd,
  output logic                 any_pressed,
  output logic [4:0]           pressed_set,
  // Configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are accepted in every cycle.
  // --------------------------------------------------------------------------
  logic [15:0] long_press_ms;
  logic [15:0] short_press_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms  <= LONG_PRESS_RESET;
      short_press_ms <= SHORT_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LONG_PRESS:  long_press_ms  <= cfg_data;
        CFG_SHORT_PRESS: short_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The pin levels are active low, so the pressed set is
  // simply their inverse and is formed on the way in.
  // --------------------------------------------------------------------------
  logic                 s1_valid;
  button_set_t          s1_set;
  logic [TIME_BITS-1:0] s1_now;
  logic                 s1_advance;
  logic                 in_accept;

  // The input register empties whenever the result register can take a value.
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_set <= ~{ok_level, down_level, up_level, right_level, left_level};
      s1_now <= now_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Hold state and evaluation of the sample in the input register.
  // --------------------------------------------------------------------------
  mode_state_t          mode_state;
  mode_state_t          mode_state_next;
  button_set_t          prev_set;
  logic [TIME_BITS-1:0] change_time;
  logic [TIME_BITS-1:0] change_time_next;

  logic                 set_changed;
  logic [TIME_BITS-1:0] base_time;
  logic [TIME_BITS-1:0] elapsed;
  logic                 past_long;
  logic                 past_short;
  logic                 ok_long;
  logic                 switch_mode;
  logic                 tv;
  thruster_cmd_t        tc;
  logic                 wv;
  windlass_cmd_t        wc;
  logic                 s1_fire;

  assign s1_fire = s1_valid && s1_advance;

  // A new set restarts the hold timer before any combination is checked,
  // which makes the elapsed time zero for that sample.
  assign set_changed = (s1_set != prev_set);
  assign base_time   = set_changed ? s1_now : change_time;
  assign elapsed     = s1_now - base_time;
  assign past_long   = elapsed > TIME_BITS'(long_press_ms);
  assign past_short  = elapsed > TIME_BITS'(short_press_ms);
  assign ok_long     = (s1_set == KEY_OK) && past_long;

  always_comb begin
    mode_state_next = mode_state;
    switch_mode     = 1'b0;
    tv              = 1'b0;
    tc              = TCMD_STOP;
    wv              = 1'b0;
    wc              = WCMD_STOP;
    case (mode_state)
      MODE_ST_STATUS: begin
        if (ok_long) begin
          mode_state_next = MODE_ST_THRUSTER;
          switch_mode     = 1'b1;
        end
      end
      MODE_ST_THRUSTER: begin
        if (ok_long) begin
          mode_state_next = MODE_ST_WINDLASS;
          switch_mode     = 1'b1;
        end else begin
          // A thruster command goes out on every sample that does not switch.
          tv = 1'b1;
          if (past_short && s1_set == KEY_RIGHT) begin
            tc = TCMD_RUN_PLUS;
          end else if (past_short && s1_set == KEY_LEFT) begin
            tc = TCMD_RUN_MINUS;
          end
        end
      end
      MODE_ST_WINDLASS: begin
        if (ok_long) begin
          mode_state_next = MODE_ST_STATUS;
          switch_mode     = 1'b1;
        end else begin
          wv = 1'b1;
          if (past_short) begin
            case (s1_set)
              KEY_UP:            wc = WCMD_RUN_PLUS;
              KEY_DOWN:          wc = WCMD_RUN_MINUS;
              KEY_UP | KEY_OK:   wc = WCMD_FORCE_PLUS;
              KEY_DOWN | KEY_OK: wc = WCMD_FORCE_MINUS;
              default:           wc = WCMD_STOP;
            endcase
          end
        end
      end
      default: begin
        // A corrupted mode falls back to status without touching the timer.
        mode_state_next = MODE_ST_STATUS;
      end
    endcase
  end

  // A mode switch restarts the hold timer as well.
  assign change_time_next = (set_changed || switch_mode) ? s1_now : change_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state  <= MODE_ST_THRUSTER;
      prev_set    <= KEY_NONE;
      change_time <= '0;
    end else if (s1_fire) begin
      mode_state  <= mode_state_next;
      prev_set    <= s1_set;
      change_time <= change_time_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mode           <= mode_code(mode_state_next);
      thruster_valid <= tv;
      thruster_cmd   <= tc;
      windlass_valid <= wv;
      windlass_cmd   <= wc;
      any_pressed    <= (s1_set != KEY_NONE);
      pressed_set    <= s1_set;
    end
  end

`ifndef SYNTH
  // The mode state never leaves its one-hot encoding.
  a_mode_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(mode_state))
    else $error("mode state is not one-hot");

  // At most one command channel is active in any result.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(thruster_valid && windlass_valid))
    else $error("thruster and windlass commands issued together");

  // Without a command the command fields read as stop.
  a_cmd_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((thruster_valid || thruster_cmd == TCMD_STOP) &&
                   (windlass_valid || windlass_cmd == WCMD_STOP)))
    else $error("command field set without a command");

  // The unused mode code never reaches the output.
  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mode != MODE_CODE_UNUSED))
    else $error("unused mode code reported");

  // The sample side stalls only when an item is waiting in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");
`endif

endmodule
